/* rtl/core/frbh_pkg.sv */
package frbh_pkg;

   // fixed field widths
   localparam int DIST_W  = 8;
   localparam int NODE_W  = 32;
   localparam int IDX_W   = 6;
   localparam int MASK_W  = 32;
   localparam int MASK_AW = 5;

   localparam int NBR_MAX_DEFAULT = 32;

   localparam logic [DIST_W-1:0] UNREACH  = 8'hFF;
   localparam logic [NODE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [MASK_W-1:0] MASK_ALL = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_STORE     = 2'd0,
      OP_UPDATE    = 2'd1,
      OP_RECOMPUTE = 2'd2,
      OP_CLEAR     = 2'd3
   } frbh_op_type;

   // request word
   typedef struct packed {
      frbh_op_type       op;
      logic [IDX_W-1:0]  neighbor_index;
      logic [NODE_W-1:0] neighbor_node;
      logic [DIST_W-1:0] neighbor_dist;
      logic [DIST_W-1:0] link_cost;
      logic [NODE_W-1:0] anchor_in;
   } frbh_req_type;

   // response word
   typedef struct packed {
      logic              changed;
      logic [DIST_W-1:0] route_dist;
      logic [DIST_W-1:0] feasible_dist;
      logic [NODE_W-1:0] best_hop;
      logic [NODE_W-1:0] route_anchor;
      logic [MASK_W-1:0] update_mask;
   } frbh_rsp_type;

   // one stored neighbour report
   typedef struct packed {
      logic [DIST_W-1:0] rep_dist;
      logic [DIST_W-1:0] cost;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] anchor;
   } frbh_entry_type;

   // verdict of the shared compare unit
   typedef struct packed {
      logic [DIST_W-1:0] path;      // saturated path distance
      logic              feas_ok;   // reported dist below feasible dist
      logic              shorter;   // path below current dist
      logic              tie_lower; // equal path, lower node id
      logic              same_hop;  // node equals current hop
      logic              take;      // recompute acceptance
   } frbh_eval_type;

endpackage

/* rtl/core/frbh_if.sv */
interface frbh_req_if;
   import frbh_pkg::*;
   logic         valid;
   logic         ready;
   frbh_req_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface frbh_rsp_if;
   import frbh_pkg::*;
   logic         valid;
   logic         ready;
   frbh_rsp_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

/* rtl/core/feasible_route_best_hop_update_unit.sv */
// channel | dir | handshake                     | word
// req     | in  | req_port.valid / .ready       | op, neighbour report fields
// rsp     | out | rsp_port.valid / .ready       | changed, route entry, update mask
//
// Store and clear words go from EXEC straight to FIN and the response register.
// Incremental update goes EXEC then FIN, or through SCAN too when the best hop
// worsens; full recompute always goes through SCAN, one slot per cycle through
// the single read port of the neighbour table and the shared compare unit.
// Synchronous reset empties the table (valid bits) and sets the route unreachable.
// A word is taken only in idle; a stalled response holds the block before idle,
// and a response still waiting does not stop the next word being accepted.
module feasible_route_best_hop_update_unit
   import frbh_pkg::*;
#(
   parameter int MAX_NEIGHBORS = NBR_MAX_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   frbh_req_if.sink    req_port,
   frbh_rsp_if.source  rsp_port
);

   localparam int AW = $clog2(MAX_NEIGHBORS);
   localparam int CW = $clog2(MAX_NEIGHBORS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type               state_ff, state_in;
   frbh_req_type            item_ff;
   logic [MAX_NEIGHBORS-1:0] valid_ff, valid_in;
   logic [DIST_W-1:0]       cur_dist_ff, cur_dist_in;
   logic [DIST_W-1:0]       cur_feas_ff, cur_feas_in;
   logic [NODE_W-1:0]       cur_hop_ff, cur_hop_in;
   logic [NODE_W-1:0]       cur_anchor_ff, cur_anchor_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    chk_ff, chk_in;
   logic                    found_ff, found_in;
   logic                    changed_ff, changed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   frbh_rsp_type            rsp_word_ff;

   logic                    req_fire;
   logic                    req_slot_ok;
   logic [IDX_W-1:0]        req_idx_m1;
   logic                    item_slot_ok;
   logic [IDX_W-1:0]        item_idx_m1;
   logic                    load_rsp;
   logic                    cnt_live;
   logic                    ram_wr_en;
   frbh_entry_type          ram_wr_data;
   frbh_entry_type          ram_rd_data;
   logic [DIST_W-1:0]       ev_dist;
   logic [DIST_W-1:0]       ev_cost;
   logic [NODE_W-1:0]       ev_node;
   frbh_eval_type           ev;

   // handshake
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.word  = rsp_word_ff;

   // slot range checks
   assign req_idx_m1   = req_port.word.neighbor_index - IDX_W'(1);
   assign req_slot_ok  = (req_port.word.neighbor_index != '0) &&
                         (req_port.word.neighbor_index <= IDX_W'(MAX_NEIGHBORS));
   assign item_idx_m1  = item_ff.neighbor_index - IDX_W'(1);
   assign item_slot_ok = (item_ff.neighbor_index != '0) &&
                         (item_ff.neighbor_index <= IDX_W'(MAX_NEIGHBORS));

   // neighbour table write on acceptance
   assign ram_wr_en = req_fire && req_slot_ok &&
                      (req_port.word.op == OP_STORE || req_port.word.op == OP_UPDATE);
   assign ram_wr_data.rep_dist = req_port.word.neighbor_dist;
   assign ram_wr_data.cost     = req_port.word.link_cost;
   assign ram_wr_data.node     = req_port.word.neighbor_node;
   assign ram_wr_data.anchor   = req_port.word.anchor_in;

   frbh_ram #(
      .WIDTH ($bits(frbh_entry_type)),
      .DEPTH (MAX_NEIGHBORS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_idx_m1[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // shared compare unit: table entry while scanning, else the held word
   always_comb begin
      if (state_ff == ST_SCAN) begin
         ev_dist = ram_rd_data.rep_dist;
         ev_cost = ram_rd_data.cost;
         ev_node = ram_rd_data.node;
      end else begin
         ev_dist = item_ff.neighbor_dist;
         ev_cost = item_ff.link_cost;
         ev_node = item_ff.neighbor_node;
      end
   end

   frbh_eval u_eval (
      .nbr_dist (ev_dist),
      .nbr_cost (ev_cost),
      .nbr_node (ev_node),
      .cur_dist (cur_dist_ff),
      .cur_feas (cur_feas_ff),
      .cur_hop  (cur_hop_ff),
      .verdict  (ev)
   );

   assign cnt_live = cnt_ff < CW'(MAX_NEIGHBORS);
   assign load_rsp = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_port.ready);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      cur_dist_in   = cur_dist_ff;
      cur_feas_in   = cur_feas_ff;
      cur_hop_in    = cur_hop_ff;
      cur_anchor_in = cur_anchor_ff;
      mask_in       = mask_ff;
      cnt_in        = cnt_ff;
      chk_in        = chk_ff;
      found_in      = found_ff;
      changed_in    = changed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;

      if (ram_wr_en) begin
         valid_in[req_idx_m1[AW-1:0]] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cnt_in   = '0;
            chk_in   = 1'b0;
            found_in = 1'b0;
            case (item_ff.op)
               OP_STORE: begin
                  changed_in = 1'b0;
                  state_in   = ST_FIN;
               end
               OP_CLEAR: begin
                  if (item_slot_ok) begin
                     mask_in = mask_ff & ~(MASK_W'(1) << item_idx_m1[MASK_AW-1:0]);
                  end
                  changed_in = 1'b0;
                  state_in   = ST_FIN;
               end
               OP_RECOMPUTE: begin
                  state_in = ST_SCAN;
               end
               OP_UPDATE: begin
                  changed_in = 1'b1;
                  state_in   = ST_FIN;
                  if (ev.feas_ok) begin
                     if (ev.shorter) begin
                        cur_dist_in   = ev.path;
                        cur_feas_in   = ev.path;
                        cur_hop_in    = item_ff.neighbor_node;
                        cur_anchor_in = item_ff.anchor_in;
                        mask_in       = MASK_ALL;
                     end else if (ev.tie_lower) begin
                        cur_hop_in = item_ff.neighbor_node;
                        if (cur_anchor_ff != item_ff.anchor_in) begin
                           cur_anchor_in = item_ff.anchor_in;
                           mask_in       = MASK_ALL;
                        end
                     end
                  end else if (ev.same_hop) begin
                     // best hop worsened: take its new distance, then rescan
                     cur_dist_in = ev.path;
                     state_in    = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_SCAN: begin
            // read slot cnt, judge the slot read last cycle
            chk_in = cnt_live && valid_ff[cnt_ff[AW-1:0]];
            if (cnt_live) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (chk_ff && ev.take) begin
               cur_dist_in   = ev.path;
               cur_feas_in   = ev.path;
               cur_hop_in    = ram_rd_data.node;
               cur_anchor_in = ram_rd_data.anchor;
               found_in      = 1'b1;
            end
            if (!cnt_live) begin
               changed_in = found_in;
               if (found_in) begin
                  mask_in = MASK_ALL;
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         cur_dist_ff   <= UNREACH;
         cur_feas_ff   <= UNREACH;
         cur_hop_ff    <= ALL_ONES;
         cur_anchor_ff <= ALL_ONES;
         mask_ff       <= '0;
         cnt_ff        <= '0;
         chk_ff        <= 1'b0;
         found_ff      <= 1'b0;
         changed_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cur_dist_ff   <= cur_dist_in;
         cur_feas_ff   <= cur_feas_in;
         cur_hop_ff    <= cur_hop_in;
         cur_anchor_ff <= cur_anchor_in;
         mask_ff       <= mask_in;
         cnt_ff        <= cnt_in;
         chk_ff        <= chk_in;
         found_ff      <= found_in;
         changed_ff    <= changed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_port.word;
      end
      if (load_rsp) begin
         rsp_word_ff.changed       <= changed_ff;
         rsp_word_ff.route_dist    <= cur_dist_ff;
         rsp_word_ff.feasible_dist <= cur_feas_ff;
         rsp_word_ff.best_hop      <= cur_hop_ff;
         rsp_word_ff.route_anchor  <= cur_anchor_ff;
         rsp_word_ff.update_mask   <= mask_ff;
      end
   end

`ifndef ASSERT_OFF
   // a finished item reaches the response register once it is free
   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_port.ready)) |=> rsp_valid_ff)
      else $error("finished word not loaded into response register");

   // store and clear never report a change
   a_no_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (item_ff.op == OP_STORE || item_ff.op == OP_CLEAR))
      |-> !changed_ff)
      else $error("store or clear reported a change");

   // a scan take never lengthens the route
   a_scan_dist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_ff && ev.take) |-> (ev.path <= cur_dist_ff))
      else $error("scan took a slot longer than the current route");

   // a scan ends with the counter exhausted
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && state_in == ST_FIN) |-> !cnt_live)
      else $error("scan left early");
`endif

endmodule

/* rtl/core/frbh_ram.sv */
module frbh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/frbh_eval.sv */
module frbh_eval
   import frbh_pkg::*;
(
   input  logic [DIST_W-1:0] nbr_dist,
   input  logic [DIST_W-1:0] nbr_cost,
   input  logic [NODE_W-1:0] nbr_node,
   input  logic [DIST_W-1:0] cur_dist,
   input  logic [DIST_W-1:0] cur_feas,
   input  logic [NODE_W-1:0] cur_hop,
   output frbh_eval_type     verdict
);

   logic [DIST_W:0]   sum;
   logic [DIST_W-1:0] path;
   logic              node_lower;

   // saturating path distance; either operand unreachable gives unreachable
   assign sum = {1'b0, nbr_dist} + {1'b0, nbr_cost};

   always_comb begin
      if (nbr_dist == UNREACH || nbr_cost == UNREACH || sum[DIST_W]) begin
         path = UNREACH;
      end else begin
         path = sum[DIST_W-1:0];
      end
   end

   assign node_lower = nbr_node < cur_hop;

   // feasibility and preference compares
   always_comb begin
      verdict.path      = path;
      verdict.feas_ok   = nbr_dist < cur_feas;
      verdict.shorter   = path < cur_dist;
      verdict.tie_lower = (path == cur_dist) && node_lower;
      verdict.same_hop  = nbr_node == cur_hop;
      verdict.take      = verdict.feas_ok && (verdict.shorter || verdict.tie_lower);
   end

endmodule

/* bench/feasible_route_best_hop_update_unit_tb.sv */
module feasible_route_best_hop_update_unit_tb;
   import frbh_pkg::*;

   localparam int NBR         = NBR_MAX_DEFAULT;
   localparam int RAND_ITEMS  = 550;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;

   frbh_req_if req_if ();
   frbh_rsp_if rsp_if ();

   feasible_route_best_hop_update_unit #(
      .MAX_NEIGHBORS(NBR)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_if),
      .rsp_port(rsp_if)
   );

   // one row of the directed stimulus
   typedef struct {
      frbh_req_type word;
      bit           typed;
      frbh_rsp_type want;
   } route_case_type;

   route_case_type route_cases[$];
   frbh_rsp_type   route_expect_q[$];

   // shadow copy of the route entry and neighbour table
   logic              nbr_live [NBR];
   frbh_entry_type    nbr_tab  [NBR];
   logic [DIST_W-1:0] route_dist_q;
   logic [DIST_W-1:0] route_feas_q;
   logic [NODE_W-1:0] route_hop_q;
   logic [NODE_W-1:0] route_anchor_q;
   logic [MASK_W-1:0] route_mask_q;

   int mismatches  = 0;
   int cycle_count = 0;
   bit quiet       = 0;   // no idling on either side
   bit hold_req    = 0;   // ask the receiver for one long hold-off

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // saturating path distance, unreachable if either leg is
   function automatic logic [DIST_W-1:0] path_dist_of(input logic [DIST_W-1:0] nd,
                                                       input logic [DIST_W-1:0] lc);
      logic [DIST_W:0] sum;
      sum = {1'b0, nd} + {1'b0, lc};
      if (nd == UNREACH || lc == UNREACH || sum > {1'b0, UNREACH})
         return UNREACH;
      return sum[DIST_W-1:0];
   endfunction

   // full scan, lowest slot first, later slots see the updated route
   function automatic bit rescan_neighbours();
      bit                found;
      logic [DIST_W-1:0] d;
      found = 1'b0;
      for (int i = 0; i < NBR; i++) begin
         if (nbr_live[i]) begin
            d = path_dist_of(nbr_tab[i].rep_dist, nbr_tab[i].cost);
            if (nbr_tab[i].rep_dist < route_feas_q &&
                (d < route_dist_q || (d == route_dist_q && nbr_tab[i].node < route_hop_q))) begin
               route_feas_q   = d;
               route_dist_q   = d;
               route_hop_q    = nbr_tab[i].node;
               route_anchor_q = nbr_tab[i].anchor;
               found          = 1'b1;
            end
         end
      end
      if (found)
         route_mask_q = MASK_ALL;
      return found;
   endfunction

   // incremental feasibility update with one report
   function automatic bit apply_report(input logic [NODE_W-1:0] node,
                                       input logic [DIST_W-1:0] nd,
                                       input logic [DIST_W-1:0] lc,
                                       input logic [NODE_W-1:0] anc);
      logic [DIST_W-1:0] d;
      d = path_dist_of(nd, lc);
      if (nd < route_feas_q) begin
         if (d < route_dist_q) begin
            route_dist_q   = d;
            route_feas_q   = d;
            route_anchor_q = anc;
            route_hop_q    = node;
            route_mask_q   = MASK_ALL;
         end else if (d == route_dist_q && node < route_hop_q) begin
            route_hop_q = node;
            if (route_anchor_q != anc) begin
               route_anchor_q = anc;
               route_mask_q   = MASK_ALL;
            end
         end
      end else if (node == route_hop_q) begin
         // current best hop got worse
         route_dist_q = d;
         return rescan_neighbours();
      end
      return 1'b1;
   endfunction

   // route entry after one request word
   function automatic frbh_rsp_type next_route(input frbh_req_type w);
      frbh_rsp_type r;
      bit           chg;
      int           idx;
      bit           in_range;
      chg      = 1'b0;
      idx      = int'(w.neighbor_index);
      in_range = (idx >= 1 && idx <= NBR);
      if ((w.op == OP_STORE || w.op == OP_UPDATE) && in_range) begin
         nbr_live[idx-1]         = 1'b1;
         nbr_tab[idx-1].rep_dist = w.neighbor_dist;
         nbr_tab[idx-1].cost     = w.link_cost;
         nbr_tab[idx-1].node     = w.neighbor_node;
         nbr_tab[idx-1].anchor   = w.anchor_in;
      end
      case (w.op)
         OP_UPDATE:    chg = apply_report(w.neighbor_node, w.neighbor_dist, w.link_cost,
                                          w.anchor_in);
         OP_RECOMPUTE: chg = rescan_neighbours();
         OP_CLEAR: begin
            if (in_range)
               route_mask_q[idx-1] = 1'b0;
         end
         default: ;
      endcase
      r.changed       = chg;
      r.route_dist    = route_dist_q;
      r.feasible_dist = route_feas_q;
      r.best_hop      = route_hop_q;
      r.route_anchor  = route_anchor_q;
      r.update_mask   = route_mask_q;
      return r;
   endfunction

   function automatic frbh_req_type mk_word(input frbh_op_type op, input int idx,
                                            input logic [NODE_W-1:0] node,
                                            input logic [DIST_W-1:0] nd,
                                            input logic [DIST_W-1:0] lc,
                                            input logic [NODE_W-1:0] anc);
      frbh_req_type w;
      w.op             = op;
      w.neighbor_index = idx[IDX_W-1:0];
      w.neighbor_node  = node;
      w.neighbor_dist  = nd;
      w.link_cost      = lc;
      w.anchor_in      = anc;
      return w;
   endfunction

   function automatic frbh_rsp_type mk_rsp(input logic chg, input logic [DIST_W-1:0] rd,
                                           input logic [DIST_W-1:0] feas,
                                           input logic [NODE_W-1:0] hop,
                                           input logic [NODE_W-1:0] anc,
                                           input logic [MASK_W-1:0] mask);
      frbh_rsp_type r;
      r.changed       = chg;
      r.route_dist    = rd;
      r.feasible_dist = feas;
      r.best_hop      = hop;
      r.route_anchor  = anc;
      r.update_mask   = mask;
      return r;
   endfunction

   function automatic void add_case(input frbh_req_type w, input bit typed,
                                    input frbh_rsp_type want);
      route_case_type c;
      c.word  = w;
      c.typed = typed;
      c.want  = want;
      route_cases.insert(route_cases.size(), c);
   endfunction

   // random word, mostly shaped from the current route so the feasibility
   // paths keep being reached; zero path distance is held back until the end,
   // as a feasible distance of zero locks the route for good
   function automatic frbh_req_type make_route_word(input bit late);
      frbh_req_type w;
      int           kind;
      int           feas;
      int           dist_now;
      int           lim;
      kind     = int'($urandom_range(99));
      feas     = int'(route_feas_q);
      dist_now = int'(route_dist_q);
      w.op             = OP_STORE;
      w.neighbor_index = IDX_W'($urandom_range(NBR, 1));
      if ($urandom_range(11) == 0)
         w.neighbor_index = $urandom_range(1) ? '0 : IDX_W'($urandom_range(63, NBR + 1));
      case ($urandom_range(3))
         0:       w.neighbor_node = $urandom_range(15);
         1:       w.neighbor_node = ALL_ONES - $urandom_range(3);
         default: w.neighbor_node = $urandom;
      endcase
      w.neighbor_dist = DIST_W'($urandom_range(255));
      w.link_cost     = ($urandom_range(3) == 0) ? DIST_W'($urandom_range(255)) :
                                                   DIST_W'($urandom_range(40));
      w.anchor_in     = $urandom_range(1) ? route_anchor_q : $urandom;

      if (kind < 30) begin
         // feasible report, often shorter
         w.op = OP_UPDATE;
         if (feas > 0)
            w.neighbor_dist = DIST_W'($urandom_range(feas - 1));
      end else if (kind < 45) begin
         // equal path through a lower node id
         w.op = OP_UPDATE;
         if (route_hop_q != 0)
            w.neighbor_node = $urandom_range(1) ? route_hop_q - 1 : $urandom_range(route_hop_q - 1);
         if (feas > 0 && dist_now == int'(UNREACH)) begin
            w.neighbor_dist = DIST_W'($urandom_range(feas - 1));
            w.link_cost     = UNREACH;
         end else if (feas > 0) begin
            lim = feas - 1;
            if (dist_now < lim)
               lim = dist_now;
            w.neighbor_dist = DIST_W'($urandom_range(lim));
            w.link_cost     = DIST_W'(dist_now - int'(w.neighbor_dist));
         end
      end else if (kind < 60) begin
         // best hop reports a worse distance
         w.op            = OP_UPDATE;
         w.neighbor_node = route_hop_q;
         w.neighbor_dist = DIST_W'($urandom_range(255, feas));
      end else if (kind < 85) begin
         w.op = (kind < 75) ? OP_STORE : OP_RECOMPUTE;
      end else if (kind < 95) begin
         w.op = OP_CLEAR;
      end else begin
         w.op             = frbh_op_type'($urandom_range(3));
         w.neighbor_index = IDX_W'($urandom_range(63));
         w.neighbor_node  = $urandom;
         w.neighbor_dist  = DIST_W'($urandom_range(255));
         w.link_cost      = DIST_W'($urandom_range(255));
         w.anchor_in      = $urandom;
      end
      if (!late && w.neighbor_dist == 0 && w.link_cost == 0)
         w.link_cost = DIST_W'(1);
      return w;
   endfunction

   function automatic int pick_gap();
      return quiet ? 0 : int'($urandom_range(16));
   endfunction

   // offer one word, predict once it is taken
   task automatic send_route_word(input frbh_req_type w, input bit typed,
                                  input frbh_rsp_type want);
      int           gap;
      frbh_rsp_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.word  <= w;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      pred = next_route(w);
      route_expect_q.insert(route_expect_q.size(), typed ? want : pred);
   endtask

   task automatic note_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // response side: random stall per word, one long hold-off on request
   initial begin
      int           stall;
      frbh_rsp_type got;
      frbh_rsp_type want;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = quiet ? 0 : int'($urandom_range(16));
         if (hold_req) begin
            hold_req = 1'b0;
            stall    = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         got = rsp_if.word;
         if (route_expect_q.size() == 0) begin
            mismatches++;
            $display("%0t unexpected word: expected none actual %0h", $time, got);
         end else begin
            want = route_expect_q.pop_front();
            note_field("changed",       32'(want.changed),       32'(got.changed));
            note_field("route_dist",    32'(want.route_dist),    32'(got.route_dist));
            note_field("feasible_dist", 32'(want.feasible_dist), 32'(got.feasible_dist));
            note_field("best_hop",      want.best_hop,           got.best_hop);
            note_field("route_anchor",  want.route_anchor,       got.route_anchor);
            note_field("update_mask",   want.update_mask,        got.update_mask);
         end
      end
   end

   // stimulus
   initial begin
      frbh_rsp_type rst_rsp;
      logic [NODE_W-1:0] anc_a;

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.word  <= '0;
      rsp_if.ready <= 1'b0;
      for (int i = 0; i < NBR; i++) begin
         nbr_live[i] = 1'b0;
         nbr_tab[i]  = '0;
      end
      route_dist_q   = UNREACH;
      route_feas_q   = UNREACH;
      route_hop_q    = ALL_ONES;
      route_anchor_q = ALL_ONES;
      route_mask_q   = '0;

      rst_rsp = mk_rsp(1'b0, UNREACH, UNREACH, ALL_ONES, ALL_ONES, '0);
      anc_a   = 32'hA5A5_0001;

      // out of range stores, clear and scan on an empty table
      add_case(mk_word(OP_STORE, 0, 32'h1234_5678, 8'd5, 8'd5, 32'd1), 1'b1, rst_rsp);
      add_case(mk_word(OP_CLEAR, 1, 32'd0, 8'd0, 8'd0, 32'd0), 1'b1, rst_rsp);
      add_case(mk_word(OP_RECOMPUTE, 1, 32'd0, 8'd0, 8'd0, 32'd0), 1'b1, rst_rsp);
      add_case(mk_word(OP_STORE, 33, 32'd9, 8'd1, 8'd1, 32'd2), 1'b1, rst_rsp);
      add_case(mk_word(OP_RECOMPUTE, 33, 32'd0, 8'd0, 8'd0, 32'd0), 1'b1, rst_rsp);
      // first route, then mask clears at both ends and out of range
      add_case(mk_word(OP_UPDATE, 1, 32'd100, 8'd200, 8'd40, anc_a), 1'b1,
               mk_rsp(1'b1, 8'd240, 8'd240, 32'd100, anc_a, MASK_ALL));
      add_case(mk_word(OP_CLEAR, 1, 32'd0, 8'd0, 8'd0, 32'd0), 1'b1,
               mk_rsp(1'b0, 8'd240, 8'd240, 32'd100, anc_a, 32'hFFFF_FFFE));
      add_case(mk_word(OP_CLEAR, 32, 32'd0, 8'd0, 8'd0, 32'd0), 1'b1,
               mk_rsp(1'b0, 8'd240, 8'd240, 32'd100, anc_a, 32'h7FFF_FFFE));
      add_case(mk_word(OP_CLEAR, 63, 32'd0, 8'd0, 8'd0, 32'd0), 1'b1,
               mk_rsp(1'b0, 8'd240, 8'd240, 32'd100, anc_a, 32'h7FFF_FFFE));
      add_case(mk_word(OP_CLEAR, 0, 32'd0, 8'd0, 8'd0, 32'd0), 1'b1,
               mk_rsp(1'b0, 8'd240, 8'd240, 32'd100, anc_a, 32'h7FFF_FFFE));
      // tie on path, lower node, same anchor: mask left alone
      add_case(mk_word(OP_UPDATE, 2, 32'd90, 8'd230, 8'd10, anc_a), 1'b1,
               mk_rsp(1'b1, 8'd240, 8'd240, 32'd90, anc_a, 32'h7FFF_FFFE));
      // tie with a new anchor
      add_case(mk_word(OP_UPDATE, 3, 32'd80, 8'd220, 8'd20, 32'h0000_BEEF), 1'b0, '0);
      // saturated sum, not feasible
      add_case(mk_word(OP_UPDATE, 4, 32'd70, 8'd250, 8'd200, 32'h1), 1'b0, '0);
      // update through an out of range slot still applies
      add_case(mk_word(OP_UPDATE, 0, 32'd60, 8'd100, 8'd50, 32'h0000_1111), 1'b0, '0);
      // extreme reports, the zero one overwritten before any scan
      add_case(mk_word(OP_STORE, 32, 32'd0, 8'd0, 8'd0, 32'd0), 1'b0, '0);
      add_case(mk_word(OP_STORE, 5, ALL_ONES, UNREACH, UNREACH, ALL_ONES), 1'b0, '0);
      add_case(mk_word(OP_STORE, 32, 32'hFFFF_FFFE, 8'd254, 8'd254, 32'd0), 1'b0, '0);
      // best hop worsens, rescan finds nothing feasible
      add_case(mk_word(OP_UPDATE, 6, 32'd60, 8'd254, 8'd1, 32'h2222), 1'b0, '0);
      // link down gives an equal unreachable path via a lower node
      add_case(mk_word(OP_UPDATE, 7, 32'd55, 8'd149, UNREACH, 32'h5555_AAAA), 1'b0, '0);
      // scan with a later slot winning the tie on node id
      add_case(mk_word(OP_STORE, 8, 32'd7, 8'd100, 8'd20, 32'h3333), 1'b0, '0);
      add_case(mk_word(OP_STORE, 9, 32'd6, 8'd110, 8'd10, 32'h4444), 1'b0, '0);
      add_case(mk_word(OP_RECOMPUTE, 1, 32'd0, 8'd0, 8'd0, 32'd0), 1'b0, '0);
      add_case(mk_word(OP_RECOMPUTE, 2, 32'd0, 8'd0, 8'd0, 32'd0), 1'b0, '0);
      add_case(mk_word(OP_CLEAR, 9, 32'd0, 8'd0, 8'd0, 32'd0), 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (route_cases[i])
         send_route_word(route_cases[i].word, route_cases[i].typed, route_cases[i].want);

      // random part in phases: no idling, long receiver hold-off, full drain
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == 110)
            quiet = 1'b1;
         if (n == 200)
            quiet = 1'b0;
         if (n == 300)
            hold_req = 1'b1;
         if (n == 400) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (route_expect_q.size() != 0) @(posedge clock);
         end
         send_route_word(make_route_word(n >= RAND_ITEMS - 6), 1'b0, '0);
      end
      req_if.valid <= 1'b0;

      // drain and settle
      while (route_expect_q.size() != 0) @(posedge clock);
      repeat (NBR + 8) @(posedge clock);
      if (mismatches == 0 && route_expect_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
